@@ rtl/ectcd_pkg.sv @@
// Shared constants, types and tables for the epoch time to civil date pipeline.
package ectcd_pkg;

  // Microseconds per day = 2^11 * 42187500; the power of two is split off first.
  localparam int                US_SHIFT    = 11;
  localparam longint unsigned   DAY_DIV     = 64'd42187500;
  localparam int                DAY_NUM_W   = 54;
  localparam int                DAY_Q_W     = 28;
  localparam int                DAY_SHIFT_W = 27;
  // Bias that makes the shifted count non-negative before the day division.
  localparam logic [DAY_NUM_W-1:0] DAY_BIAS = DAY_NUM_W'(DAY_DIV) << DAY_SHIFT_W;

  localparam longint unsigned   US_PER_HOUR   = 64'd3600000000;
  localparam longint unsigned   US_PER_MINUTE = 64'd60000000;
  localparam longint unsigned   US_PER_SECOND = 64'd1000000;
  localparam int                TOD_W         = 37;

  // Calendar constants.
  localparam longint unsigned   DAYS_400Y     = 64'd146097;
  localparam int                DAYS_4Y       = 1460;
  localparam int                DAYS_100Y     = 36524;
  localparam int                DAYS_400Y_M1  = 146096;
  localparam longint unsigned   DAYS_YEAR     = 64'd365;
  localparam longint unsigned   MONTH_DIV     = 64'd153;
  localparam int                ERA_BIAS      = 1024;
  localparam int                EPOCH_SHIFT   = 719468;
  localparam int                Z_W           = 28;
  // Day quotient carries +2^27; shift it to days from 0000-03-01 plus ERA_BIAS eras.
  localparam int                Z_OFS = ERA_BIAS * 146097 + EPOCH_SHIFT - (1 << DAY_SHIFT_W);
  localparam int                ERA_W  = 11;
  localparam int                DOE_W  = 18;
  localparam int                YOE_W  = 9;
  localparam int                DOY_W  = 9;
  localparam int                MPN_W  = 11;
  localparam int                MP_W   = 4;
  localparam int                YB_W   = 21;
  localparam int                YEAR_LIMIT = 32767;

  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [19:0] usec;
  } ectcd_tod_t;

  // First day of year (March based) for each shifted month: (153*mp+2)/5.
  function automatic logic [DOY_W-1:0] mp_day_base(input logic [MP_W-1:0] mp);
    logic [DOY_W-1:0] base;
    unique case (mp)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd61;
      4'd3:    base = 9'd92;
      4'd4:    base = 9'd122;
      4'd5:    base = 9'd153;
      4'd6:    base = 9'd184;
      4'd7:    base = 9'd214;
      4'd8:    base = 9'd245;
      4'd9:    base = 9'd275;
      4'd10:   base = 9'd306;
      4'd11:   base = 9'd337;
      default: base = 9'd0;
    endcase
    return base;
  endfunction

endpackage

@@ rtl/ectcd_cdiv.sv @@
// Pipelined restoring divider by a constant, one quotient bit per stage.
module ectcd_cdiv #(
  parameter int              NUM_W  = 8,
  parameter longint unsigned DIV    = 3,
  parameter int              Q_W    = 4,
  parameter int              SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_v,
  input  logic [NUM_W-1:0]         in_num,
  input  logic [SIDE_W-1:0]        in_side,
  output logic                     out_v,
  output logic [Q_W-1:0]           out_q,
  output logic [$clog2(DIV)-1:0]   out_rem,
  output logic [SIDE_W-1:0]        out_side
);

  localparam int R_W = $clog2(DIV);

  logic [R_W-1:0]    rem_r  [Q_W];
  logic [Q_W-1:0]    q_r    [Q_W];
  logic [Q_W-1:0]    lo_r   [Q_W];
  logic [SIDE_W-1:0] side_r [Q_W];
  logic [Q_W-1:0]    v_r;

  logic [R_W-1:0]    rem_p  [Q_W];
  logic [Q_W-1:0]    q_p    [Q_W];
  logic [Q_W-1:0]    lo_p   [Q_W];
  logic [SIDE_W-1:0] side_p [Q_W];
  logic [Q_W-1:0]    v_p;

  // Upper dividend bits are already below the divisor and seed the remainder.
  assign rem_p[0]  = R_W'(in_num[NUM_W-1:Q_W]);
  assign q_p[0]    = '0;
  assign lo_p[0]   = in_num[Q_W-1:0];
  assign side_p[0] = in_side;
  assign v_p[0]    = in_v;

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [R_W:0]   t;
    logic           ge;
    logic [R_W-1:0] rem_nxt;
    logic [Q_W-1:0] q_nxt;

    if (k > 0) begin : g_link
      assign rem_p[k]  = rem_r[k-1];
      assign q_p[k]    = q_r[k-1];
      assign lo_p[k]   = lo_r[k-1];
      assign side_p[k] = side_r[k-1];
      assign v_p[k]    = v_r[k-1];
    end

    assign t  = {rem_p[k], lo_p[k][Q_W-1-k]};
    assign ge = (t >= (R_W+1)'(DIV));

    always_comb begin
      rem_nxt = ge ? R_W'(t - (R_W+1)'(DIV)) : R_W'(t);
      q_nxt = q_p[k];
      q_nxt[Q_W-1-k] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_p[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        q_r[k]    <= q_nxt;
        lo_r[k]   <= lo_p[k];
        side_r[k] <= side_p[k];
      end
    end
  end

  assign out_v    = v_r[Q_W-1];
  assign out_q    = q_r[Q_W-1];
  assign out_rem  = rem_r[Q_W-1];
  assign out_side = side_r[Q_W-1];

  // Quotient must fit in Q_W bits, else the seeded remainder is already too big.
  a_num_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_v |-> (64'(in_num[NUM_W-1:Q_W]) < DIV))
    else $error("cdiv dividend exceeds quotient width");

endmodule

@@ rtl/ectcd_date.sv @@
// Day count (March based, biased by whole eras) to year base, day of year and month index.
module ectcd_date #(
  parameter int SIDE_W = 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_v,
  input  logic [ectcd_pkg::Z_W-1:0]           in_z,
  input  logic [SIDE_W-1:0]                   in_side,
  output logic                                out_v,
  output logic signed [ectcd_pkg::YB_W-1:0]   out_yb,
  output logic [ectcd_pkg::DOY_W-1:0]         out_doy,
  output logic [ectcd_pkg::MP_W-1:0]          out_mp,
  output logic [SIDE_W-1:0]                   out_side
);

  localparam int ERA_W = ectcd_pkg::ERA_W;
  localparam int DOE_W = ectcd_pkg::DOE_W;
  localparam int YOE_W = ectcd_pkg::YOE_W;
  localparam int DOY_W = ectcd_pkg::DOY_W;
  localparam int YB_W  = ectcd_pkg::YB_W;
  localparam int MPN_W = ectcd_pkg::MPN_W;
  localparam int MP_W  = ectcd_pkg::MP_W;
  localparam int B_W   = ERA_W + DOE_W + SIDE_W;
  localparam int F_W   = DOY_W + YB_W + SIDE_W;

  // era and day of era
  logic              v_a;
  logic [ERA_W-1:0]  era_a;
  logic [DOE_W-1:0]  doe_a;
  logic [SIDE_W-1:0] side_a;

  ectcd_cdiv #(
    .NUM_W (ectcd_pkg::Z_W),
    .DIV   (ectcd_pkg::DAYS_400Y),
    .Q_W   (ERA_W),
    .SIDE_W(SIDE_W)
  ) u_era (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (in_v),
    .in_num  (in_z),
    .in_side (in_side),
    .out_v   (v_a),
    .out_q   (era_a),
    .out_rem (doe_a),
    .out_side(side_a)
  );

  // doe / 1460
  logic              v_b;
  logic [6:0]        q4y_b;
  logic [B_W-1:0]    pk_b;
  logic [ERA_W-1:0]  era_b;
  logic [DOE_W-1:0]  doe_b;
  logic [SIDE_W-1:0] side_b;

  ectcd_cdiv #(
    .NUM_W (DOE_W),
    .DIV   (64'(ectcd_pkg::DAYS_4Y)),
    .Q_W   (7),
    .SIDE_W(B_W)
  ) u_leap (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (v_a),
    .in_num  (doe_a),
    .in_side ({era_a, doe_a, side_a}),
    .out_v   (v_b),
    .out_q   (q4y_b),
    .out_rem (),
    .out_side(pk_b)
  );

  assign {era_b, doe_b, side_b} = pk_b;

  // leap-corrected day count
  logic [2:0]        c100_b;
  logic [DOE_W-1:0]  n_nxt;
  logic [DOE_W-1:0]  n_c_r;
  logic [B_W-1:0]    pk_c_r;
  logic              v_c_r;

  always_comb begin
    c100_b = 3'(doe_b >= DOE_W'(ectcd_pkg::DAYS_100Y))
           + 3'(doe_b >= DOE_W'(2 * ectcd_pkg::DAYS_100Y))
           + 3'(doe_b >= DOE_W'(3 * ectcd_pkg::DAYS_100Y))
           + 3'(doe_b >= DOE_W'(ectcd_pkg::DAYS_400Y_M1));
    n_nxt = doe_b - DOE_W'(q4y_b) + DOE_W'(c100_b)
          - DOE_W'(doe_b == DOE_W'(ectcd_pkg::DAYS_400Y_M1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_c_r <= 1'b0;
    end else if (en) begin
      v_c_r <= v_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_c_r  <= n_nxt;
      pk_c_r <= pk_b;
    end
  end

  // year of era
  logic              v_d;
  logic [YOE_W-1:0]  yoe_d;
  logic [B_W-1:0]    pk_d;
  logic [ERA_W-1:0]  era_d;
  logic [DOE_W-1:0]  doe_d;
  logic [SIDE_W-1:0] side_d;

  ectcd_cdiv #(
    .NUM_W (DOE_W),
    .DIV   (ectcd_pkg::DAYS_YEAR),
    .Q_W   (YOE_W),
    .SIDE_W(B_W)
  ) u_yoe (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (v_c_r),
    .in_num  (n_c_r),
    .in_side (pk_c_r),
    .out_v   (v_d),
    .out_q   (yoe_d),
    .out_rem (),
    .out_side(pk_d)
  );

  assign {era_d, doe_d, side_d} = pk_d;

  // day of year and year base
  logic [1:0]        c100_d;
  logic [DOY_W-1:0]  doy_nxt;
  logic [YB_W-1:0]   yb_nxt;
  logic [DOY_W-1:0]  doy_e_r;
  logic [YB_W-1:0]   yb_e_r;
  logic [SIDE_W-1:0] side_e_r;
  logic              v_e_r;

  always_comb begin
    c100_d = 2'(yoe_d >= YOE_W'(100)) + 2'(yoe_d >= YOE_W'(200)) + 2'(yoe_d >= YOE_W'(300));
    doy_nxt = DOY_W'(19'(doe_d) - (19'(yoe_d) * 19'd365 + 19'(yoe_d[YOE_W-1:2]) - 19'(c100_d)));
    yb_nxt = YB_W'(yoe_d) + YB_W'(era_d) * YB_W'(400) - YB_W'(ectcd_pkg::ERA_BIAS * 400);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_e_r <= 1'b0;
    end else if (en) begin
      v_e_r <= v_d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      doy_e_r  <= doy_nxt;
      yb_e_r   <= yb_nxt;
      side_e_r <= side_d;
    end
  end

  // month numerator 5*doy+2
  logic [MPN_W-1:0]  mpn_f_r;
  logic [F_W-1:0]    pk_f_r;
  logic              v_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_f_r <= 1'b0;
    end else if (en) begin
      v_f_r <= v_e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mpn_f_r <= MPN_W'(doy_e_r) * MPN_W'(5) + MPN_W'(2);
      pk_f_r  <= {doy_e_r, yb_e_r, side_e_r};
    end
  end

  logic [F_W-1:0] pk_g;

  ectcd_cdiv #(
    .NUM_W (MPN_W),
    .DIV   (ectcd_pkg::MONTH_DIV),
    .Q_W   (MP_W),
    .SIDE_W(F_W)
  ) u_month (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (v_f_r),
    .in_num  (mpn_f_r),
    .in_side (pk_f_r),
    .out_v   (out_v),
    .out_q   (out_mp),
    .out_rem (),
    .out_side(pk_g)
  );

  logic [YB_W-1:0] yb_g;

  assign {out_doy, yb_g, out_side} = pk_g;
  assign out_yb = $signed(yb_g);

  a_doy_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_e_r |-> (doy_e_r <= DOY_W'(365)))
    else $error("day of year out of range");

endmodule

@@ rtl/epoch_time_to_civil_date_top.sv @@
// Top level: signed epoch microseconds to proleptic Gregorian date and time of day.
//
// Input channel: in_valid / in_stall with in_epoch_microseconds, a signed count
// of microseconds since 1970-01-01 00:00:00 UTC. Output channel: out_valid /
// out_stall with year, month, day, hour, minute, second, fraction_ns and
// out_range_error. A word moves when valid is high and stall is low.
// Every input word gives exactly one output word, in order.
// From acceptance to out_valid a word passes one bias stage, 28 stages
// of the day division, one stage, 17 stages of the hour/minute/second split,
// 34 stages of the date conversion and the output register. Throughput is one
// word per cycle while out_stall does not hold the pipeline. Times outside
// years -32767..32767 raise out_range_error with all other fields zero.
// The whole pipeline advances on one enable; in_stall is high exactly while a
// result sits in the output register and out_stall is high, and then every
// stage holds its word. Reset clears all valid bits; data registers are not
// reset.
module epoch_time_to_civil_date_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [63:0] in_epoch_microseconds,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_year,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day,
  output logic [4:0]         out_hour,
  output logic [5:0]         out_minute,
  output logic [5:0]         out_second,
  output logic [29:0]        out_fraction_ns,
  output logic               out_range_error
);

  localparam int NUM_W  = ectcd_pkg::DAY_NUM_W;
  localparam int Z_W    = ectcd_pkg::Z_W;
  localparam int TOD_W  = ectcd_pkg::TOD_W;
  localparam int SH     = ectcd_pkg::US_SHIFT;
  localparam int YB_W   = ectcd_pkg::YB_W;
  localparam int DOY_W  = ectcd_pkg::DOY_W;
  localparam int MP_W   = ectcd_pkg::MP_W;
  localparam int TODS_W = $bits(ectcd_pkg::ectcd_tod_t);

  logic en;
  logic out_valid_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // bias stage: floor by 2^11, then offset so the day division sees a non-negative value
  logic [NUM_W-1:0] u_r;
  logic [SH-1:0]    lo_r;
  logic             v0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r  <= NUM_W'(in_epoch_microseconds >>> SH) + ectcd_pkg::DAY_BIAS;
      lo_r <= in_epoch_microseconds[SH-1:0];
    end
  end

  logic                         v_dd;
  logic [ectcd_pkg::DAY_Q_W-1:0] dq;
  logic [25:0]                  drem;
  logic [SH-1:0]                dlo;

  ectcd_cdiv #(
    .NUM_W (NUM_W),
    .DIV   (ectcd_pkg::DAY_DIV),
    .Q_W   (ectcd_pkg::DAY_Q_W),
    .SIDE_W(SH)
  ) u_day (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (v0_r),
    .in_num  (u_r),
    .in_side (lo_r),
    .out_v   (v_dd),
    .out_q   (dq),
    .out_rem (drem),
    .out_side(dlo)
  );

  // day count rebased to March-first eras, time of day in microseconds
  logic [Z_W-1:0]   z1_r;
  logic [TOD_W-1:0] tod1_r;
  logic             v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_dd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z1_r   <= Z_W'(dq) + Z_W'(ectcd_pkg::Z_OFS);
      tod1_r <= {drem, dlo};
    end
  end

  // hour
  logic           v_h;
  logic [4:0]     hour_h;
  logic [31:0]    rem_h;
  logic [Z_W-1:0] z_h;

  ectcd_cdiv #(
    .NUM_W (TOD_W),
    .DIV   (ectcd_pkg::US_PER_HOUR),
    .Q_W   (5),
    .SIDE_W(Z_W)
  ) u_hour (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (v1_r),
    .in_num  (tod1_r),
    .in_side (z1_r),
    .out_v   (v_h),
    .out_q   (hour_h),
    .out_rem (rem_h),
    .out_side(z_h)
  );

  // minute
  logic           v_m;
  logic [5:0]     min_m;
  logic [25:0]    rem_m;
  logic [Z_W+4:0] pk_m;

  ectcd_cdiv #(
    .NUM_W (32),
    .DIV   (ectcd_pkg::US_PER_MINUTE),
    .Q_W   (6),
    .SIDE_W(Z_W + 5)
  ) u_minute (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (v_h),
    .in_num  (rem_h),
    .in_side ({z_h, hour_h}),
    .out_v   (v_m),
    .out_q   (min_m),
    .out_rem (rem_m),
    .out_side(pk_m)
  );

  // second
  logic            v_s;
  logic [5:0]      sec_s;
  logic [19:0]     us_s;
  logic [Z_W+10:0] pk_s;

  ectcd_cdiv #(
    .NUM_W (26),
    .DIV   (ectcd_pkg::US_PER_SECOND),
    .Q_W   (6),
    .SIDE_W(Z_W + 11)
  ) u_second (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (v_m),
    .in_num  (rem_m),
    .in_side ({pk_m, min_m}),
    .out_v   (v_s),
    .out_q   (sec_s),
    .out_rem (us_s),
    .out_side(pk_s)
  );

  logic [Z_W-1:0]        z_s;
  logic [4:0]            hour_s;
  logic [5:0]            min_s;
  ectcd_pkg::ectcd_tod_t tod_s;

  assign {z_s, hour_s, min_s} = pk_s;

  always_comb begin
    tod_s.hour   = hour_s;
    tod_s.minute = min_s;
    tod_s.second = sec_s;
    tod_s.usec   = us_s;
  end

  // calendar date
  logic                   v_g;
  logic signed [YB_W-1:0] yb_g;
  logic [DOY_W-1:0]       doy_g;
  logic [MP_W-1:0]        mp_g;
  logic [TODS_W-1:0]      tod_g_bits;
  ectcd_pkg::ectcd_tod_t  tod_g;

  ectcd_date #(
    .SIDE_W(TODS_W)
  ) u_date (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (v_s),
    .in_z    (z_s),
    .in_side (tod_s),
    .out_v   (v_g),
    .out_yb  (yb_g),
    .out_doy (doy_g),
    .out_mp  (mp_g),
    .out_side(tod_g_bits)
  );

  assign tod_g = ectcd_pkg::ectcd_tod_t'(tod_g_bits);

  // final assembly and range check
  logic [DOY_W-1:0]       base_g;
  logic [4:0]             day_g;
  logic [3:0]             month_g;
  logic signed [YB_W-1:0] year_g;
  logic                   err_g;

  always_comb begin
    base_g  = ectcd_pkg::mp_day_base(mp_g);
    day_g   = 5'(doy_g - base_g + DOY_W'(1));
    month_g = (mp_g < MP_W'(10)) ? mp_g + MP_W'(3) : mp_g - MP_W'(9);
    // Jan and Feb belong to the next civil year
    year_g  = yb_g + $signed({{(YB_W-1){1'b0}}, (month_g <= 4'd2)});
    err_g   = (year_g > YB_W'(ectcd_pkg::YEAR_LIMIT)) ||
              (year_g < YB_W'(-ectcd_pkg::YEAR_LIMIT));
  end

  logic signed [15:0] year_r;
  logic [3:0]         month_r;
  logic [4:0]         day_r;
  logic [4:0]         hour_r;
  logic [5:0]         minute_r;
  logic [5:0]         second_r;
  logic [29:0]        frac_r;
  logic               err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_g;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err_r <= err_g;
      if (err_g) begin
        year_r   <= '0;
        month_r  <= '0;
        day_r    <= '0;
        hour_r   <= '0;
        minute_r <= '0;
        second_r <= '0;
        frac_r   <= '0;
      end else begin
        year_r   <= 16'(year_g);
        month_r  <= month_g;
        day_r    <= day_g;
        hour_r   <= tod_g.hour;
        minute_r <= tod_g.minute;
        second_r <= tod_g.second;
        frac_r   <= 30'(tod_g.usec) * 30'd1000;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_year        = year_r;
  assign out_month       = month_r;
  assign out_day         = day_r;
  assign out_hour        = hour_r;
  assign out_minute      = minute_r;
  assign out_second      = second_r;
  assign out_fraction_ns = frac_r;
  assign out_range_error = err_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |-> out_year == 16'sd0 && out_month == 4'd0 &&
      out_day == 5'd0 && out_hour == 5'd0 && out_minute == 6'd0 &&
      out_second == 6'd0 && out_fraction_ns == 30'd0)
    else $error("range error word carries nonzero fields");

  a_date_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_range_error |-> out_month >= 4'd1 && out_month <= 4'd12 &&
      out_day >= 5'd1 && out_day <= 5'd31)
    else $error("illegal month or day");

  a_time_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_range_error |-> out_hour <= 5'd23 && out_minute <= 6'd59 &&
      out_second <= 6'd59 && out_fraction_ns <= 30'd999999000)
    else $error("illegal time of day");

endmodule

@@ dv/ectcd_stamp_checker.sv @@
// Scoreboard for the epoch time to civil date block: predicts each output word and compares it.
module ectcd_stamp_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [63:0] in_epoch_microseconds,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_year,
  input  logic [3:0]         out_month,
  input  logic [4:0]         out_day,
  input  logic [4:0]         out_hour,
  input  logic [5:0]         out_minute,
  input  logic [5:0]         out_second,
  input  logic [29:0]        out_fraction_ns,
  input  logic               out_range_error,
  output int                 error_count,
  output int                 outstanding
);

  localparam longint US_DAY    = 64'sd86400000000;
  localparam longint US_HOUR   = 64'sd3600000000;
  localparam longint US_MINUTE = 64'sd60000000;
  localparam longint US_SECOND = 64'sd1000000;
  localparam longint YEAR_MAX  = 64'sd32767;

  typedef struct packed {
    logic signed [15:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [29:0]        fraction_ns;
    logic               range_error;
  } civil_stamp_t;

  civil_stamp_t stamp_q[$];

  function automatic civil_stamp_t civil_from_epoch_us(input logic signed [63:0] epoch_us);
    longint       whole_days;
    longint       rem_us;
    longint       shifted;
    longint       era;
    longint       day_of_era;
    longint       year_of_era;
    longint       day_of_year;
    longint       month_idx;
    longint       mday;
    longint       mon;
    longint       yr;
    civil_stamp_t stamp;
    whole_days = epoch_us / US_DAY;
    rem_us     = epoch_us % US_DAY;
    // floor division: negative times belong to the earlier day
    if (rem_us < 0) begin
      rem_us     = rem_us + US_DAY;
      whole_days = whole_days - 1;
    end
    // days counted from 0000-03-01, in 400-year eras
    shifted     = whole_days + 64'sd719468;
    era         = ((shifted >= 0) ? shifted : shifted - 64'sd146096) / 64'sd146097;
    day_of_era  = shifted - era * 64'sd146097;
    year_of_era = (day_of_era - day_of_era / 64'sd1460 + day_of_era / 64'sd36524
                   - day_of_era / 64'sd146096) / 64'sd365;
    day_of_year = day_of_era - (64'sd365 * year_of_era + year_of_era / 64'sd4
                                - year_of_era / 64'sd100);
    month_idx   = (64'sd5 * day_of_year + 64'sd2) / 64'sd153;
    mday        = day_of_year - (64'sd153 * month_idx + 64'sd2) / 64'sd5 + 64'sd1;
    mon         = (month_idx < 10) ? month_idx + 64'sd3 : month_idx - 64'sd9;
    yr          = year_of_era + era * 64'sd400;
    if (mon <= 2) yr = yr + 1;
    stamp = '0;
    if (yr < -YEAR_MAX || yr > YEAR_MAX) begin
      stamp.range_error = 1'b1;
    end else begin
      stamp.year        = yr[15:0];
      stamp.month       = mon[3:0];
      stamp.day         = mday[4:0];
      stamp.hour        = 5'(rem_us / US_HOUR);
      stamp.minute      = 6'((rem_us % US_HOUR) / US_MINUTE);
      stamp.second      = 6'((rem_us % US_MINUTE) / US_SECOND);
      stamp.fraction_ns = 30'((rem_us % US_SECOND) * 64'sd1000);
    end
    return stamp;
  endfunction

  initial begin
    error_count = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    civil_stamp_t want;
    civil_stamp_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) stamp_q.push_back(civil_from_epoch_us(in_epoch_microseconds));
      if (out_valid && !out_stall) begin
        got = {out_year, out_month, out_day, out_hour, out_minute, out_second,
               out_fraction_ns, out_range_error};
        if (stamp_q.size() == 0) begin
          if (error_count < 10)
            $display("%0t: output word with nothing pending: year %0d month %0d day %0d rng %0b",
                     $realtime, $signed(got.year), got.month, got.day, got.range_error);
          error_count = error_count + 1;
        end else begin
          want = stamp_q.pop_front();
          if (got != want) begin
            if (error_count < 10) begin
              $display("%0t: mismatch exp %0d-%0d-%0d %0d:%0d:%0d.%0d rng %0b",
                       $realtime, $signed(want.year), want.month, want.day, want.hour,
                       want.minute, want.second, want.fraction_ns, want.range_error);
              $display("%0t:          got %0d-%0d-%0d %0d:%0d:%0d.%0d rng %0b",
                       $realtime, $signed(got.year), got.month, got.day, got.hour,
                       got.minute, got.second, got.fraction_ns, got.range_error);
            end
            error_count = error_count + 1;
          end
        end
      end
      outstanding = stamp_q.size();
    end
  end

endmodule

@@ dv/tb_epoch_time_to_civil_date_top.sv @@
// Testbench top for epoch_time_to_civil_date_top: clock, reset, stimulus, output stalls, verdict.
module tb_epoch_time_to_civil_date_top;

  localparam longint US_DAY = 64'sd86400000000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [63:0] in_epoch_microseconds;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] out_year;
  logic [3:0]         out_month;
  logic [4:0]         out_day;
  logic [4:0]         out_hour;
  logic [5:0]         out_minute;
  logic [5:0]         out_second;
  logic [29:0]        out_fraction_ns;
  logic               out_range_error;

  int                 error_count;
  int                 outstanding;
  int                 sender_mode;
  logic               hold_request;

  epoch_time_to_civil_date_top dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_epoch_microseconds (in_epoch_microseconds),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_year              (out_year),
    .out_month             (out_month),
    .out_day               (out_day),
    .out_hour              (out_hour),
    .out_minute            (out_minute),
    .out_second            (out_second),
    .out_fraction_ns       (out_fraction_ns),
    .out_range_error       (out_range_error)
  );

  ectcd_stamp_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_epoch_microseconds (in_epoch_microseconds),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_year              (out_year),
    .out_month             (out_month),
    .out_day               (out_day),
    .out_hour              (out_hour),
    .out_minute            (out_minute),
    .out_second            (out_second),
    .out_fraction_ns       (out_fraction_ns),
    .out_range_error       (out_range_error),
    .error_count           (error_count),
    .outstanding           (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // 0: never wait, 1: a uniform random wait, 2: mostly back to back with an occasional gap
  function automatic int draw_wait(input int mode);
    int n;
    case (mode)
      0:       n = 0;
      1:       n = $urandom_range(0, 19);
      default: n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
    endcase
    return n;
  endfunction

  // Microseconds since the epoch for a proleptic Gregorian date plus time of day.
  // Day values past the month end simply roll into the next month.
  function automatic longint epoch_us_at(input longint yr, input longint mon, input longint mday,
                                         input longint tod_us);
    longint y;
    longint era;
    longint yoe;
    longint doy;
    longint doe;
    y   = (mon <= 2) ? yr - 1 : yr;
    era = ((y >= 0) ? y : y - 399) / 400;
    yoe = y - era * 400;
    doy = (153 * ((mon > 2) ? mon - 3 : mon + 9) + 2) / 5 + mday - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return (era * 146097 + doe - 719468) * US_DAY + tod_us;
  endfunction

  task automatic send_word(input longint word);
    int gap;
    gap = draw_wait(sender_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid              <= 1'b1;
    in_epoch_microseconds <= word;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_drained;
    while (outstanding != 0) @(negedge clk);
  endtask

  // receiver: random stall per word, plus one long hold-off when requested
  initial begin : receiver
    int   stall_left;
    int   rx_mode;
    int   taken;
    logic held;
    out_stall  = 1'b0;
    stall_left = 0;
    rx_mode    = 1;
    taken      = 0;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        taken = taken + 1;
        if (taken % 40 == 0) rx_mode = $urandom_range(0, 2);
        stall_left = draw_wait(rx_mode);
      end
      if (hold_request && !held) begin
        held       = 1'b1;
        stall_left = 300;
      end
      @(negedge clk);
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left = stall_left - 1;
    end
  end

  initial begin : stimulus
    longint word;
    longint yr;
    longint mon;
    longint mday;
    longint tod;
    int     kind;
    rst_n                 = 1'b0;
    in_valid              = 1'b0;
    in_epoch_microseconds = '0;
    hold_request          = 1'b0;
    sender_mode           = 1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: field extremes, day/year boundaries, leap rules, range edges
    send_word(0);
    send_word(-1);
    send_word(1);
    send_word(64'sh7FFF_FFFF_FFFF_FFFF);
    send_word(64'sh8000_0000_0000_0000);
    send_word(64'sh5555_5555_5555_5555);
    send_word(64'shAAAA_AAAA_AAAA_AAAA);
    send_word(US_DAY - 1);
    send_word(-US_DAY);
    send_word(epoch_us_at(32767, 12, 31, US_DAY - 1));
    send_word(epoch_us_at(32768, 1, 1, 0));
    send_word(epoch_us_at(-32767, 1, 1, 0));
    send_word(epoch_us_at(-32767, 1, 1, 0) - 1);
    send_word(epoch_us_at(2000, 2, 29, 64'sd45296789012));
    send_word(epoch_us_at(1900, 2, 28, US_DAY - 1));
    send_word(epoch_us_at(1900, 3, 1, 0));
    send_word(epoch_us_at(2100, 3, 1, 0));
    send_word(epoch_us_at(0, 2, 29, 12345));
    send_word(epoch_us_at(-1, 12, 31, US_DAY - 1));
    send_word(epoch_us_at(-4, 2, 29, 64'sd3600000001));
    send_word(epoch_us_at(1600, 12, 31, 64'sd86399000000));
    send_word(epoch_us_at(2038, 1, 19, 64'sd11647000000));
    send_word(epoch_us_at(-32768, 12, 31, US_DAY - 1));
    in_valid <= 1'b0;
    wait_drained();

    for (int i = 0; i < 1650; i++) begin
      if (i % 50 == 0) sender_mode = (i >= 400 && i < 650) ? 0 : $urandom_range(0, 2);
      // long receiver hold-off while the sender keeps offering words
      if (i == 400) hold_request = 1'b1;
      if (i == 1000) begin
        in_valid <= 1'b0;
        wait_drained();
        @(negedge clk);
      end
      kind = $urandom_range(0, 99);
      tod  = longint'({$urandom, $urandom} % 64'd86400000000);
      if (kind < 50) begin
        yr   = longint'($urandom_range(0, 65534)) - 32767;
        mon  = $urandom_range(1, 12);
        mday = $urandom_range(1, 31);
        word = epoch_us_at(yr, mon, mday, tod);
      end else if (kind < 65) begin
        case ($urandom_range(0, 3))
          0:       yr = -32768;
          1:       yr = -32767;
          2:       yr = 32767;
          default: yr = 32768;
        endcase
        mon  = $urandom_range(0, 1) ? 64'sd1 : 64'sd12;
        mday = (mon == 1) ? $urandom_range(1, 2) : $urandom_range(30, 31);
        if ($urandom_range(0, 3) == 0) tod = $urandom_range(0, 1) ? US_DAY - 1 : 64'sd0;
        word = epoch_us_at(yr, mon, mday, tod);
      end else if (kind < 80) begin
        word = longint'({$urandom, $urandom}) >>> $urandom_range(0, 63);
      end else if (kind < 90) begin
        yr   = longint'($urandom_range(0, 4000)) - 2000;
        word = epoch_us_at(yr, $urandom_range(1, 12), $urandom_range(1, 31), 0)
               + longint'($urandom_range(0, 4)) - 2;
      end else begin
        word = longint'({$urandom, $urandom});
      end
      send_word(word);
    end
    in_valid <= 1'b0;

    wait_drained();
    repeat (120) @(negedge clk);
    if (error_count == 0) begin
      $display("tb_epoch_time_to_civil_date_top: done, clean");
    end else begin
      $display("tb_epoch_time_to_civil_date_top: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("tb_epoch_time_to_civil_date_top: done, errors");
    $finish;
  end

endmodule
